>>> hw/rtl/mbt_pkg.sv
// ============================================================================
// mbt_pkg
// Shared types and constants for the USB-MIDI dual-ring transmit batcher.
// ============================================================================
package mbt_pkg;

    // Sizing of the engine.
    localparam int DEVICES      = 4;
    localparam int NORMAL_DEPTH = 32;
    localparam int RT_DEPTH     = 8;
    localparam int BATCH_MAX    = 31;

    // Field widths of the channel payloads.
    localparam int FUNC_W  = 2;
    localparam int DEV_W   = 2;
    localparam int CABLE_W = 4;
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 3;
    localparam int WORD_W  = 32;
    localparam int CNT_W   = 5;
    localparam int CIN_W   = 4;

    // Derived widths for indexes and memory addresses.
    localparam int DEV_IDX_W   = (DEVICES > 1) ? $clog2(DEVICES) : 1;
    localparam int NP_W        = $clog2(NORMAL_DEPTH);
    localparam int RT_W        = $clog2(RT_DEPTH);
    localparam int IDX_W       = (NP_W > RT_W) ? NP_W : RT_W;
    localparam int NRM_ENTRIES = DEVICES * NORMAL_DEPTH;
    localparam int RT_ENTRIES  = DEVICES * RT_DEPTH;
    localparam int NRM_AW      = $clog2(NRM_ENTRIES);
    localparam int RT_AW       = (RT_ENTRIES > 1) ? $clog2(RT_ENTRIES) : 1;

    // MIDI status codes that need special handling.
    localparam logic [BYTE_W-1:0] ST_RT_MIN   = 8'hF8;
    localparam logic [BYTE_W-1:0] ST_MTC      = 8'hF1;
    localparam logic [BYTE_W-1:0] ST_SONG_POS = 8'hF2;
    localparam logic [BYTE_W-1:0] ST_SONG_SEL = 8'hF3;
    localparam logic [CIN_W-1:0]  CIN_THREE   = 4'h3;
    localparam logic [CIN_W-1:0]  CIN_TWO     = 4'h2;

    // Request codes on the input channel.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_ENQUEUE  = 2'd0,
        FUNC_COMPLETE = 2'd1,
        FUNC_PLUG     = 2'd2
    } func_t;

    // Result codes on the output channel.
    typedef enum logic [KIND_W-1:0] {
        KIND_QUEUED   = 3'd0,
        KIND_DROPPED  = 3'd1,
        KIND_REJECTED = 3'd2,
        KIND_WORD     = 3'd3,
        KIND_IDLE     = 3'd4,
        KIND_PLUG     = 3'd5
    } kind_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  load;
        logic  emit;
        kind_t emit_kind;
        logic  emit_last;
        logic  enqueue;
        logic  set_busy;
        logic  clr_busy;
        logic  advance;
        logic  plug;
        logic  batch_start;
        logic  batch_step;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        func_t func;
        logic  dev_ok;
        logic  connected;
        logic  busy;
        logic  ring_full;
        logic  pending;
        logic  out_free;
        logic  batch_last;
    } dp_status_t;

endpackage

>>> hw/rtl/mbt_item_if.sv
// ============================================================================
// mbt_item_if
// Input channel: one request transaction per valid/ready handshake.
// ============================================================================
interface mbt_item_if
    import mbt_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [DEV_W-1:0]   device;
    logic [CABLE_W-1:0] cable;
    logic [BYTE_W-1:0]  status_byte;
    logic [BYTE_W-1:0]  data_one;
    logic [BYTE_W-1:0]  data_two;
    logic               plug;

    modport source (
        output valid, func, device, cable, status_byte, data_one, data_two, plug,
        input  ready
    );

    modport sink (
        input  valid, func, device, cable, status_byte, data_one, data_two, plug,
        output ready
    );
endinterface

>>> hw/rtl/mbt_result_if.sv
// ============================================================================
// mbt_result_if
// Output channel: one result transaction per valid/ready handshake.
// ============================================================================
interface mbt_result_if
    import mbt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [DEV_W-1:0]  out_device;
    logic [WORD_W-1:0] event_word;
    logic              from_realtime;
    logic [CNT_W-1:0]  batch_count;
    logic              last;

    modport source (
        output valid, kind, out_device, event_word, from_realtime, batch_count, last,
        input  ready
    );

    modport sink (
        input  valid, kind, out_device, event_word, from_realtime, batch_count, last,
        output ready
    );
endinterface

>>> hw/rtl/mbt_ctrl.sv
// ============================================================================
// mbt_ctrl
// Controller: sequences one request at a time through the datapath.
// ============================================================================
module mbt_ctrl
    import mbt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_CHAIN,
        S_BSTART,
        S_BATCH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.emit_kind = KIND_IDLE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid && ready_reg)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (status.func)
                    FUNC_ENQUEUE:
                    begin
                        if (status.out_free)
                        begin
                            cmd.emit = 1'b1;
                            if (!status.dev_ok || !status.connected)
                            begin
                                cmd.emit_kind = KIND_REJECTED;
                                cmd.emit_last = 1'b1;
                                state_next    = S_IDLE;
                            end
                            else if (status.ring_full)
                            begin
                                cmd.emit_kind = KIND_DROPPED;
                                cmd.emit_last = 1'b1;
                                state_next    = S_IDLE;
                            end
                            else
                            begin
                                // An idle device starts a batch right behind the queued result.
                                cmd.emit_kind = KIND_QUEUED;
                                cmd.emit_last = status.busy;
                                cmd.enqueue   = 1'b1;
                                cmd.set_busy  = !status.busy;
                                state_next    = status.busy ? S_IDLE : S_BSTART;
                            end
                        end
                    end
                    FUNC_COMPLETE:
                    begin
                        if (!status.dev_ok)
                        begin
                            state_next = S_IDLE;
                        end
                        else if (!status.busy)
                        begin
                            if (status.out_free)
                            begin
                                cmd.emit      = 1'b1;
                                cmd.emit_kind = KIND_IDLE;
                                cmd.emit_last = 1'b1;
                                state_next    = S_IDLE;
                            end
                        end
                        else
                        begin
                            cmd.advance = 1'b1;
                            state_next  = S_CHAIN;
                        end
                    end
                    FUNC_PLUG:
                    begin
                        if (!status.dev_ok)
                        begin
                            state_next = S_IDLE;
                        end
                        else if (status.out_free)
                        begin
                            cmd.plug      = 1'b1;
                            cmd.emit      = 1'b1;
                            cmd.emit_kind = KIND_PLUG;
                            cmd.emit_last = 1'b1;
                            state_next    = S_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_CHAIN:
            begin
                // After a completion, either chain the next batch or go idle.
                if (status.pending)
                begin
                    state_next = S_BSTART;
                end
                else if (status.out_free)
                begin
                    cmd.clr_busy  = 1'b1;
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = KIND_IDLE;
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_BSTART:
            begin
                cmd.batch_start = 1'b1;
                state_next      = S_BATCH;
            end
            S_BATCH:
            begin
                if (status.out_free)
                begin
                    cmd.batch_step = 1'b1;
                    cmd.emit       = 1'b1;
                    cmd.emit_kind  = KIND_WORD;
                    cmd.emit_last  = status.batch_last;
                    if (status.batch_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered ready.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= (state_next == S_IDLE);
        end
    end

    assign item_ready = ready_reg;

endmodule

>>> hw/rtl/mbt_dp.sv
// ============================================================================
// mbt_dp
// Datapath: per-device ring pointers, the two ring memories, event packing
// and the output register.
// ============================================================================
module mbt_dp
    import mbt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [FUNC_W-1:0]  func,
    input  logic [DEV_W-1:0]   device,
    input  logic [CABLE_W-1:0] cable,
    input  logic [BYTE_W-1:0]  status_byte,
    input  logic [BYTE_W-1:0]  data_one,
    input  logic [BYTE_W-1:0]  data_two,
    input  logic               plug,
    input  dp_cmd_t            cmd,
    output dp_status_t         status,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [KIND_W-1:0]  kind,
    output logic [DEV_W-1:0]   out_device,
    output logic [WORD_W-1:0]  event_word,
    output logic               from_realtime,
    output logic [CNT_W-1:0]   batch_count,
    output logic               last
);

    // Latched request.
    logic [FUNC_W-1:0]  func_reg;
    logic [DEV_W-1:0]   dev_reg;
    logic [CABLE_W-1:0] cable_reg;
    logic [BYTE_W-1:0]  st_reg;
    logic [BYTE_W-1:0]  d1_reg;
    logic [BYTE_W-1:0]  d2_reg;
    logic               plug_reg;

    // Per-device state.
    logic              conn_reg    [DEVICES];
    logic              busy_reg    [DEVICES];
    logic [NP_W-1:0]   n_get_reg   [DEVICES];
    logic [NP_W-1:0]   n_put_reg   [DEVICES];
    logic [NP_W-1:0]   n_fly_reg   [DEVICES];
    logic [RT_W-1:0]   rt_get_reg  [DEVICES];
    logic [RT_W-1:0]   rt_put_reg  [DEVICES];
    logic [RT_W-1:0]   rt_fly_reg  [DEVICES];
    logic              rt_send_reg [DEVICES];

    // Batch progress.
    logic [IDX_W-1:0] bidx_reg;
    logic [CNT_W-1:0] bremain_reg;
    logic [CNT_W-1:0] bcnt_reg;
    logic             brt_reg;

    // Output register.
    logic              out_valid_reg;
    logic [KIND_W-1:0] kind_reg;
    logic [DEV_W-1:0]  odev_reg;
    logic [WORD_W-1:0] word_reg;
    logic              ort_reg;
    logic [CNT_W-1:0]  ocnt_reg;
    logic              last_reg;

    // Ring memories.
    logic [WORD_W-1:0] nrm_mem [NRM_ENTRIES];
    logic [WORD_W-1:0] rt_mem  [RT_ENTRIES];
    logic [WORD_W-1:0] nrm_rdata;
    logic [WORD_W-1:0] rt_rdata;

    logic [DEV_IDX_W-1:0] dev_idx;
    logic [CIN_W-1:0]     cin;
    logic [WORD_W-1:0]    packed_word;
    logic                 is_rt;
    logic [NP_W-1:0]      n_get;
    logic [NP_W-1:0]      n_put;
    logic [NP_W-1:0]      n_put_inc;
    logic [RT_W-1:0]      rt_get;
    logic [RT_W-1:0]      rt_put;
    logic [RT_W-1:0]      rt_put_inc;
    logic [NP_W:0]        n_sum;
    logic [NP_W-1:0]      n_adv;
    logic [RT_W:0]        rt_sum;
    logic [RT_W-1:0]      rt_adv;
    logic [NP_W:0]        n_run;
    logic [RT_W:0]        rt_run;
    logic [NP_W-1:0]      n_run_cap;
    logic [RT_W-1:0]      rt_run_cap;
    logic                 sel_rt;
    logic [CNT_W-1:0]     run;
    logic [IDX_W-1:0]     start_idx;
    logic [IDX_W-1:0]     idx_next;
    logic [NRM_AW-1:0]    nrm_wa;
    logic [NRM_AW-1:0]    nrm_ra;
    logic [RT_AW-1:0]     rt_wa;
    logic [RT_AW-1:0]     rt_ra;
    logic                 out_free;

    assign dev_idx = DEV_IDX_W'(dev_reg);

    // Event packing: code index from the status byte, cable in the high nibble.
    always_comb
    begin
        priority if (st_reg == ST_SONG_POS)
        begin
            cin = CIN_THREE;
        end
        else if (st_reg == ST_MTC || st_reg == ST_SONG_SEL)
        begin
            cin = CIN_TWO;
        end
        else
        begin
            cin = st_reg[BYTE_W-1:BYTE_W-CIN_W];
        end
    end

    assign packed_word = {cable_reg, cin, st_reg, d1_reg, d2_reg};
    assign is_rt       = (st_reg >= ST_RT_MIN);

    // Current device's pointers.
    assign n_get  = n_get_reg[dev_idx];
    assign n_put  = n_put_reg[dev_idx];
    assign rt_get = rt_get_reg[dev_idx];
    assign rt_put = rt_put_reg[dev_idx];

    assign n_put_inc  = (n_put == NP_W'(NORMAL_DEPTH - 1)) ? '0 : n_put + NP_W'(1);
    assign rt_put_inc = (rt_put == RT_W'(RT_DEPTH - 1)) ? '0 : rt_put + RT_W'(1);

    // Completion advance; the sent run never crosses the ring end.
    assign n_sum  = {1'b0, n_get} + {1'b0, n_fly_reg[dev_idx]};
    assign n_adv  = (n_sum >= (NP_W+1)'(NORMAL_DEPTH))
                    ? NP_W'(n_sum - (NP_W+1)'(NORMAL_DEPTH)) : NP_W'(n_sum);
    assign rt_sum = {1'b0, rt_get} + {1'b0, rt_fly_reg[dev_idx]};
    assign rt_adv = (rt_sum >= (RT_W+1)'(RT_DEPTH))
                    ? RT_W'(rt_sum - (RT_W+1)'(RT_DEPTH)) : RT_W'(rt_sum);

    // Batch length: the contiguous run up to the put index or the ring end, capped at BATCH_MAX.
    assign n_run  = (n_put >= n_get) ? (NP_W+1)'(n_put - n_get)
                                     : (NP_W+1)'(NORMAL_DEPTH) - {1'b0, n_get};
    assign rt_run = (rt_put > rt_get) ? (RT_W+1)'(rt_put - rt_get)
                                      : (RT_W+1)'(RT_DEPTH) - {1'b0, rt_get};
    assign n_run_cap  = (n_run > (NP_W+1)'(BATCH_MAX)) ? NP_W'(BATCH_MAX) : NP_W'(n_run);
    assign rt_run_cap = (rt_run > (RT_W+1)'(BATCH_MAX)) ? RT_W'(BATCH_MAX) : RT_W'(rt_run);

    assign sel_rt    = (rt_get != rt_put);
    assign run       = sel_rt ? CNT_W'(rt_run_cap) : CNT_W'(n_run_cap);
    assign start_idx = sel_rt ? IDX_W'(rt_get) : IDX_W'(n_get);

    // The read address runs one step ahead so that read data lines up with bidx_reg.
    always_comb
    begin
        priority if (cmd.batch_start)
        begin
            idx_next = start_idx;
        end
        else if (cmd.batch_step)
        begin
            idx_next = bidx_reg + IDX_W'(1);
        end
        else
        begin
            idx_next = bidx_reg;
        end
    end

    assign nrm_wa = NRM_AW'(int'(dev_idx) * NORMAL_DEPTH + int'(n_put));
    assign nrm_ra = NRM_AW'(int'(dev_idx) * NORMAL_DEPTH + int'(NP_W'(idx_next)));
    assign rt_wa  = RT_AW'(int'(dev_idx) * RT_DEPTH + int'(rt_put));
    assign rt_ra  = RT_AW'(int'(dev_idx) * RT_DEPTH + int'(RT_W'(idx_next)));

    // Ring memories: one write and one registered read each.
    always_ff @(posedge clk)
    begin
        if (cmd.enqueue && !is_rt)
        begin
            nrm_mem[nrm_wa] <= packed_word;
        end
        nrm_rdata <= nrm_mem[nrm_ra];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.enqueue && is_rt)
        begin
            rt_mem[rt_wa] <= packed_word;
        end
        rt_rdata <= rt_mem[rt_ra];
    end

    // Request latch.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg  <= func;
            dev_reg   <= device;
            cable_reg <= cable;
            st_reg    <= status_byte;
            d1_reg    <= data_one;
            d2_reg    <= data_two;
            plug_reg  <= plug;
        end
    end

    // Per-device state updates.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEVICES; i++)
            begin
                conn_reg[i]    <= 1'b0;
                busy_reg[i]    <= 1'b0;
                n_get_reg[i]   <= '0;
                n_put_reg[i]   <= '0;
                n_fly_reg[i]   <= '0;
                rt_get_reg[i]  <= '0;
                rt_put_reg[i]  <= '0;
                rt_fly_reg[i]  <= '0;
                rt_send_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (cmd.enqueue)
            begin
                if (is_rt)
                begin
                    rt_put_reg[dev_idx] <= rt_put_inc;
                end
                else
                begin
                    n_put_reg[dev_idx] <= n_put_inc;
                end
            end
            if (cmd.set_busy)
            begin
                busy_reg[dev_idx] <= 1'b1;
            end
            if (cmd.clr_busy)
            begin
                busy_reg[dev_idx] <= 1'b0;
            end
            // Completion retires the ring that was in flight.
            if (cmd.advance)
            begin
                if (rt_send_reg[dev_idx])
                begin
                    rt_get_reg[dev_idx] <= rt_adv;
                    rt_fly_reg[dev_idx] <= '0;
                end
                else
                begin
                    n_get_reg[dev_idx] <= n_adv;
                    n_fly_reg[dev_idx] <= '0;
                end
            end
            // The realtime ring takes precedence when a batch starts.
            if (cmd.batch_start)
            begin
                rt_send_reg[dev_idx] <= sel_rt;
                if (sel_rt)
                begin
                    rt_fly_reg[dev_idx] <= rt_run_cap;
                end
                else
                begin
                    n_fly_reg[dev_idx] <= n_run_cap;
                end
            end
            if (cmd.plug)
            begin
                conn_reg[dev_idx]    <= plug_reg;
                busy_reg[dev_idx]    <= 1'b0;
                n_get_reg[dev_idx]   <= '0;
                n_put_reg[dev_idx]   <= '0;
                n_fly_reg[dev_idx]   <= '0;
                rt_get_reg[dev_idx]  <= '0;
                rt_put_reg[dev_idx]  <= '0;
                rt_fly_reg[dev_idx]  <= '0;
                rt_send_reg[dev_idx] <= 1'b0;
            end
        end
    end

    // Batch progress registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bremain_reg <= '0;
        end
        else if (cmd.batch_start)
        begin
            bremain_reg <= run;
        end
        else if (cmd.batch_step)
        begin
            bremain_reg <= bremain_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        bidx_reg <= idx_next;
        if (cmd.batch_start)
        begin
            bcnt_reg <= run;
            brt_reg  <= sel_rt;
        end
    end

    // Output register: a new result loads when the slot is empty or being taken.
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            kind_reg <= cmd.emit_kind;
            odev_reg <= dev_reg;
            last_reg <= cmd.emit_last;
            unique case (cmd.emit_kind)
                KIND_QUEUED, KIND_DROPPED:
                begin
                    word_reg <= packed_word;
                    ort_reg  <= is_rt;
                    ocnt_reg <= '0;
                end
                KIND_WORD:
                begin
                    word_reg <= brt_reg ? rt_rdata : nrm_rdata;
                    ort_reg  <= brt_reg;
                    ocnt_reg <= bcnt_reg;
                end
                default:
                begin
                    word_reg <= '0;
                    ort_reg  <= 1'b0;
                    ocnt_reg <= '0;
                end
            endcase
        end
    end

    // Status toward the controller.
    always_comb
    begin
        status.func       = func_t'(func_reg);
        status.dev_ok     = (int'(dev_reg) < DEVICES);
        status.connected  = conn_reg[dev_idx];
        status.busy       = busy_reg[dev_idx];
        status.ring_full  = is_rt ? (rt_put_inc == rt_get) : (n_put_inc == n_get);
        status.pending    = (rt_get != rt_put) || (n_get != n_put);
        status.out_free   = out_free;
        status.batch_last = (bremain_reg == CNT_W'(1));
    end

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign out_device    = odev_reg;
    assign event_word    = word_reg;
    assign from_realtime = ort_reg;
    assign batch_count   = ocnt_reg;
    assign last          = last_reg;

endmodule

>>> hw/rtl/midi_dual_ring_tx_batcher.sv
// ============================================================================
// midi_dual_ring_tx_batcher
// Per-device USB-MIDI transmit engine with a realtime ring and a normal ring.
// ============================================================================
//
//   channel   dir   transaction carries
//   -------   ---   ---------------------------------------------------------
//   item      in    func, device, cable, status_byte, data_one, data_two, plug
//   result    out   kind, out_device, event_word, from_realtime, batch_count,
//                   last
//
// One request is handled at a time: it is loaded and then executed. A completion
// that ends a batch passes the chain state as well. An enqueue that starts a
// batch passes the batch start state and then sends one batch word (up to 31)
// per cycle while the result channel does not stall, since the ring memory
// delivers one registered read per cycle; a completion that chains a batch
// passes the chain state first. A result channel stall holds the sequencer in
// place. Reset clears all per-device state and needs no clearing pass.
//
module midi_dual_ring_tx_batcher
    import mbt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    mbt_item_if.sink    item,
    mbt_result_if.source result
);

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       in_ready;

    // Sequencer.
    mbt_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (in_ready),
        .status     (status),
        .cmd        (cmd)
    );

    // Rings, pointers and the output register.
    mbt_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .func          (item.func),
        .device        (item.device),
        .cable         (item.cable),
        .status_byte   (item.status_byte),
        .data_one      (item.data_one),
        .data_two      (item.data_two),
        .plug          (item.plug),
        .cmd           (cmd),
        .status        (status),
        .out_valid     (result.valid),
        .out_ready     (result.ready),
        .kind          (result.kind),
        .out_device    (result.out_device),
        .event_word    (result.event_word),
        .from_realtime (result.from_realtime),
        .batch_count   (result.batch_count),
        .last          (result.last)
    );

    assign item.ready = in_ready;

endmodule
